@@ src/mpc_pkg.sv @@
// Package: sizes, command codes, register indexes and shared types of the max-plus convolver.
`default_nettype none
package mpc_pkg;

	localparam int MAX_A  = 256;
	localparam int MAX_B  = 256;
	localparam int A_AW   = $clog2(MAX_A);
	localparam int B_AW   = $clog2(MAX_B);
	localparam int LEN_W  = 9;
	localparam int IDX_W  = 9;
	localparam int VAL_W  = 62;
	localparam int RES_W  = 63;

	localparam logic signed [RES_W-1:0] FLOOR_VAL = -(63'sd1 <<< 60);

	typedef enum logic [1:0] {
		CMD_LOAD_A = 2'd0,
		CMD_LOAD_B = 2'd1,
		CMD_QUERY  = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	localparam logic REG_LEN_A = 1'b0;
	localparam logic REG_LEN_B = 1'b1;

	typedef struct packed {
		logic             start;
		logic [IDX_W-1:0] idx;
		logic [LEN_W-1:0] la;
		logic [LEN_W-1:0] lb;
	} query_req_t;

endpackage
`default_nettype wire

@@ src/max_plus_convolution_top.sv @@
// Top level of the max-plus convolver: command intake, length registers, element stores, query engine.
//
// channel  direction  handshake           payload
// cmd      in         cmd_valid/cmd_stall command, index, value
// res      out        res_valid/res_stall result_value, out_of_range
// cfg      in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// A load is written to its store when the command is taken. A query reads its n valid pairs
// through the single read port of each store, feeding one add and compare per cycle; an
// out-of-range query skips the scan. Reset clears control and the length registers to 1; the
// stores are not cleared. cmd_stall is high while a query runs; a waiting result holds only the
// finish of the next query, loads still go through.
`default_nettype none
module max_plus_convolution_top (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cmd_valid,
	output logic                                     cmd_stall,
	input  wire logic [1:0]                          command,
	input  wire logic [mpc_pkg::IDX_W-1:0]           index,
	input  wire logic signed [mpc_pkg::VAL_W-1:0]    value,
	output logic                                     res_valid,
	input  wire logic                                res_stall,
	output logic signed [mpc_pkg::RES_W-1:0]         result_value,
	output logic                                     out_of_range,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic                                cfg_index,
	input  wire logic [mpc_pkg::LEN_W-1:0]           cfg_data
);

	logic [mpc_pkg::LEN_W-1:0] len_a_q;
	logic [mpc_pkg::LEN_W-1:0] len_b_q;
	logic [mpc_pkg::LEN_W-1:0] eff_la;
	logic [mpc_pkg::LEN_W-1:0] eff_lb;
	logic                      busy;
	logic                      take;
	logic                      a_we;
	logic                      b_we;
	logic [mpc_pkg::A_AW-1:0]  a_raddr;
	logic [mpc_pkg::B_AW-1:0]  b_raddr;
	logic [mpc_pkg::VAL_W-1:0] a_rdata;
	logic [mpc_pkg::VAL_W-1:0] b_rdata;
	mpc_pkg::query_req_t       req;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_a_q <= 9'd1;
			len_b_q <= 9'd1;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == mpc_pkg::REG_LEN_A) begin
				len_a_q <= cfg_data;
			end else begin
				len_b_q <= cfg_data;
			end
		end
	end

	always_comb begin
		eff_la    = (int'(len_a_q) > mpc_pkg::MAX_A) ? mpc_pkg::LEN_W'(mpc_pkg::MAX_A) : len_a_q;
		eff_lb    = (int'(len_b_q) > mpc_pkg::MAX_B) ? mpc_pkg::LEN_W'(mpc_pkg::MAX_B) : len_b_q;
		cmd_stall = busy;
		take      = cmd_valid && !cmd_stall;
		a_we      = take && (command == mpc_pkg::CMD_LOAD_A) && (index < eff_la);
		b_we      = take && (command == mpc_pkg::CMD_LOAD_B) && (index < eff_lb);
		req.start = take && (command == mpc_pkg::CMD_QUERY);
		req.idx   = index;
		req.la    = eff_la;
		req.lb    = eff_lb;
	end

	mpc_ram #(
		.DEPTH (mpc_pkg::MAX_A),
		.WIDTH (mpc_pkg::VAL_W)
	) u_a_store (
		.clk   (clk),
		.we    (a_we),
		.waddr (mpc_pkg::A_AW'(index)),
		.wdata (value),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	mpc_ram #(
		.DEPTH (mpc_pkg::MAX_B),
		.WIDTH (mpc_pkg::VAL_W)
	) u_b_store (
		.clk   (clk),
		.we    (b_we),
		.waddr (mpc_pkg::B_AW'(index)),
		.wdata (value),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	mpc_query u_query (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.busy         (busy),
		.a_raddr      (a_raddr),
		.b_raddr      (b_raddr),
		.a_rdata      (a_rdata),
		.b_rdata      (b_rdata),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.result_value (result_value),
		.out_of_range (out_of_range)
	);

endmodule
`default_nettype wire

@@ src/mpc_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module mpc_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 62
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

@@ src/mpc_query.sv @@
// Query sequencer: scans the valid pairs of both stores and holds the maximum in a result register.
`default_nettype none
module mpc_query (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire mpc_pkg::query_req_t             req,
	output logic                                 busy,
	output logic      [mpc_pkg::A_AW-1:0]        a_raddr,
	output logic      [mpc_pkg::B_AW-1:0]        b_raddr,
	input  wire logic [mpc_pkg::VAL_W-1:0]       a_rdata,
	input  wire logic [mpc_pkg::VAL_W-1:0]       b_rdata,
	output logic                                 res_valid,
	input  wire logic                            res_stall,
	output logic signed [mpc_pkg::RES_W-1:0]     result_value,
	output logic                                 out_of_range
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_DONE
	} state_t;

	state_t                            state_q;
	logic [mpc_pkg::IDX_W-1:0]         j_q;
	logic [mpc_pkg::IDX_W-1:0]         jhi_q;
	logic [mpc_pkg::IDX_W-1:0]         idx_q;
	logic signed [mpc_pkg::RES_W-1:0]  best_q;
	logic                              oor_q;
	logic                              rd_v_s1;
	logic                              sum_v_s2;
	logic signed [mpc_pkg::RES_W-1:0]  sum_s2;

	logic [mpc_pkg::IDX_W:0]           idx_p1;
	logic [mpc_pkg::IDX_W:0]           idx_p2;
	logic [mpc_pkg::IDX_W:0]           len_sum;
	logic                              in_range;
	logic [mpc_pkg::IDX_W-1:0]         jlo;
	logic [mpc_pkg::IDX_W-1:0]         jhi;
	logic [mpc_pkg::IDX_W-1:0]         la_m1;
	logic [mpc_pkg::IDX_W-1:0]         b_off;
	logic                              out_free;

	always_comb begin
		idx_p1   = {1'b0, req.idx} + 10'd1;
		idx_p2   = {1'b0, req.idx} + 10'd2;
		len_sum  = {1'b0, req.la} + {1'b0, req.lb};
		in_range = (req.la != '0) && (req.lb != '0) && (idx_p2 <= len_sum);
		jlo      = (idx_p1 > {1'b0, req.lb}) ? 9'(idx_p1 - {1'b0, req.lb}) : '0;
		la_m1    = req.la - 9'd1;
		jhi      = (req.idx < la_m1) ? req.idx : la_m1;
		b_off    = idx_q - j_q;
		a_raddr  = mpc_pkg::A_AW'(j_q);
		b_raddr  = mpc_pkg::B_AW'(b_off);
		out_free = !res_valid || !res_stall;
		busy     = (state_q != S_IDLE);
	end

	always_ff @(posedge clk) begin
		sum_s2 <= $signed({a_rdata[mpc_pkg::VAL_W-1], a_rdata})
			+ $signed({b_rdata[mpc_pkg::VAL_W-1], b_rdata});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			rd_v_s1      <= 1'b0;
			sum_v_s2     <= 1'b0;
			res_valid    <= 1'b0;
			j_q          <= '0;
			jhi_q        <= '0;
			idx_q        <= '0;
			best_q       <= mpc_pkg::FLOOR_VAL;
			oor_q        <= 1'b1;
			result_value <= mpc_pkg::FLOOR_VAL;
			out_of_range <= 1'b1;
		end else begin
			rd_v_s1  <= 1'b0;
			sum_v_s2 <= rd_v_s1;
			if (sum_v_s2 && (sum_s2 > best_q)) begin
				best_q <= sum_s2;
			end
			if (res_valid && !res_stall) begin
				res_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.start) begin
						idx_q  <= req.idx;
						j_q    <= jlo;
						jhi_q  <= jhi;
						best_q <= mpc_pkg::FLOOR_VAL;
						oor_q  <= !in_range;
						state_q <= in_range ? S_SCAN : S_DONE;
					end
				end
				S_SCAN: begin
					rd_v_s1 <= 1'b1;
					if (j_q == jhi_q) begin
						state_q <= S_DRAIN;
					end else begin
						j_q <= j_q + 9'd1;
					end
				end
				S_DRAIN: begin
					if (!rd_v_s1 && !sum_v_s2) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						res_valid    <= 1'b1;
						result_value <= best_q;
						out_of_range <= oor_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire
